### hdl/twodo_pkg.sv
// Shared types and constants of the tracking wheel odometry core.
package twodo_pkg;

    localparam logic signed [63:0] DEG_TURN      = 64'sd23592960;
    localparam logic signed [63:0] DEG_HALF_TURN = 64'sd11796480;
    localparam logic signed [63:0] DEG_TWO_TURNS = 64'sd47185920;
    localparam logic signed [63:0] ONE_Q30       = 64'sd1073741824;
    localparam logic signed [63:0] TWO_Q30       = 64'sd2147483648;
    localparam logic signed [63:0] ARC_DIV       = 64'sd25769803776;
    localparam logic signed [63:0] GAIN_Q30      = 64'sd652032874;
    localparam logic signed [63:0] PI_Q30        = 64'sd3373259426;
    localparam logic signed [63:0] INV_PI_Q30    = 64'sd341782638;
    localparam logic signed [63:0] RAD2DEG_Q16   = 64'sd3754936;
    localparam logic signed [63:0] SMALL_H       = 64'sd58671;
    localparam logic signed [63:0] TRAVEL_DIV    = 64'sd36000;
    localparam logic signed [63:0] CD_PER_DEG    = 64'sd100;
    localparam logic signed [63:0] DEG_Q16       = 64'sd65536;
    localparam logic signed [63:0] TURN_Q32      = 64'sd4294967296;
    localparam logic signed [63:0] HALF_TURN_Q31 = 64'sd2147483648;
    localparam logic signed [63:0] UNIT_ONE      = 64'sd1;
    localparam logic signed [63:0] GYRO_FULL     = 64'sd36000;
    localparam logic [63:0]        MAX64         = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        CFG_LEFT_TRAVEL   = 3'd0,
        CFG_RIGHT_TRAVEL  = 3'd1,
        CFG_STRAFE_TRAVEL = 3'd2,
        CFG_LEFT_OFFSET   = 3'd3,
        CFG_RIGHT_OFFSET  = 3'd4,
        CFG_STRAFE_OFFSET = 3'd5,
        CFG_GYRO_SCALE    = 3'd6,
        CFG_USE_GYRO      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] d;
    } t_md_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] q;
        logic [63:0]        rem;
    } t_md_rsp;

    // CORDIC step angles, 2^-32 turn
    function automatic logic signed [63:0] atan_turn(input logic [4:0] i);
        logic signed [63:0] v;
        unique case (i)
            5'd0:  v = 64'sd536870912;
            5'd1:  v = 64'sd316933406;
            5'd2:  v = 64'sd167458907;
            5'd3:  v = 64'sd85004756;
            5'd4:  v = 64'sd42667331;
            5'd5:  v = 64'sd21354465;
            5'd6:  v = 64'sd10679838;
            5'd7:  v = 64'sd5340245;
            5'd8:  v = 64'sd2670163;
            5'd9:  v = 64'sd1335087;
            5'd10: v = 64'sd667544;
            5'd11: v = 64'sd333772;
            5'd12: v = 64'sd166886;
            5'd13: v = 64'sd83443;
            5'd14: v = 64'sd41722;
            5'd15: v = 64'sd20861;
            5'd16: v = 64'sd10430;
            5'd17: v = 64'sd5215;
            5'd18: v = 64'sd2608;
            5'd19: v = 64'sd1304;
            5'd20: v = 64'sd652;
            5'd21: v = 64'sd326;
            5'd22: v = 64'sd163;
            5'd23: v = 64'sd81;
            default: v = 64'sd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/twodo_in_if.sv
// Input word channel: sensor update or set-pose request.
interface twodo_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] left_angle;
    logic signed [31:0] right_angle;
    logic signed [31:0] strafe_angle;
    logic [15:0]        gyro_heading;
    logic signed [47:0] new_x;
    logic signed [47:0] new_y;
    logic signed [47:0] new_heading;
    logic [2:0]         set_mask;

    modport source (
        output valid, req_type, left_angle, right_angle, strafe_angle, gyro_heading,
               new_x, new_y, new_heading, set_mask,
        input  ready
    );
    modport sink (
        input  valid, req_type, left_angle, right_angle, strafe_angle, gyro_heading,
               new_x, new_y, new_heading, set_mask,
        output ready
    );
endinterface

### hdl/twodo_out_if.sv
// Output word channel: pose after each request.
interface twodo_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] pose_x;
    logic signed [47:0] pose_y;
    logic signed [47:0] pose_heading;
    logic               gyro_write;
    logic               saturated;

    modport source (
        output valid, pose_x, pose_y, pose_heading, gyro_write, saturated,
        input  ready
    );
    modport sink (
        input  valid, pose_x, pose_y, pose_heading, gyro_write, saturated,
        output ready
    );
endinterface

### hdl/tracking_wheel_odometry_core.sv
// Tracking wheel arc odometry core: sequencer, CORDIC and pose state around one muldiv unit.
// A sensor update runs some 25 multiply-divides through the single shared unit, each of 4
// partial products, 64 restoring divide steps and rounding, plus two CORDIC runs (fewer of
// both when the heading does not change). A set-pose word goes straight to the output, or
// through two multiply-divides when a heading is set with the IMU in use. The input is
// ready only while the sequencer is idle; a finished word waits in the output register
// while the next request is worked on.
module tracking_wheel_odometry_core #(
    parameter int POSE_WIDTH = 48,
    parameter int TRIG_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [24:0] i_cfg_data,
    twodo_in_if.sink    i_in,
    twodo_out_if.source o_out
);
    import twodo_pkg::*;

    localparam int NSTEP = (TRIG_STEPS < 24) ? TRIG_STEPS : 24;
    localparam logic [4:0] IT_LAST = 5'(NSTEP - 1);
    localparam logic signed [65:0] P_MAX = (66'sd1 <<< (POSE_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] P_MIN = -P_MAX - 66'sd1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_CORD  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef enum logic [19:0] {
        P_DL   = 20'h00001,
        P_DR   = 20'h00002,
        P_DS   = 20'h00004,
        P_DH   = 20'h00008,
        T_MOD  = 20'h00010,
        T_TURN = 20'h00020,
        T_ZR   = 20'h00040,
        T_S    = 20'h00080,
        T_C    = 20'h00100,
        A_A    = 20'h00200,
        A_B    = 20'h00400,
        A_C    = 20'h00800,
        P_DY1  = 20'h01000,
        P_DY2  = 20'h02000,
        P_DX1  = 20'h04000,
        P_DX2  = 20'h08000,
        P_X1   = 20'h10000,
        P_X2   = 20'h20000,
        P_Y1   = 20'h40000,
        P_Y2   = 20'h80000
    } t_step;

    typedef enum logic [2:0] {
        M_ARC  = 3'b001,
        M_HEAD = 3'b010,
        M_GSET = 3'b100
    } t_mode;

    typedef struct packed {
        logic                         flag;
        logic signed [POSE_WIDTH-1:0] val;
    } t_sat;

    function automatic t_sat sat_add(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
        logic signed [65:0] s;
        t_sat               r;
        s      = 66'(a) + 66'(b);
        r.flag = 1'b0;
        r.val  = s[POSE_WIDTH-1:0];
        if (s > P_MAX) begin
            r.flag = 1'b1;
            r.val  = P_MAX[POSE_WIDTH-1:0];
        end else if (s < P_MIN) begin
            r.flag = 1'b1;
            r.val  = P_MIN[POSE_WIDTH-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [23:0]        r_lwt, r_rwt, r_swt;
    logic signed [24:0] r_lo, r_ro, r_so;
    logic [17:0]        r_gs;
    logic               r_use_gyro;

    // odometry state
    logic signed [31:0]           r_last_l, r_last_r, r_last_s;
    logic [15:0]                  r_last_g;
    logic signed [POSE_WIDTH-1:0] r_px, r_py, r_ph;

    // sequencer and work registers
    t_state             r_state;
    t_step              r_step;
    t_mode              r_mode;
    logic signed [32:0] r_del_l, r_del_r, r_del_s;
    logic signed [16:0] r_del_g;
    logic signed [63:0] r_dl, r_dr, r_ds, r_dh, r_c, r_sh, r_hs, r_hc;
    logic signed [63:0] r_dx, r_dy, r_t, r_s, r_ang;
    logic               r_two, r_sat, r_gw;
    logic signed [63:0] r_cx, r_cy, r_cz;
    logic [1:0]         r_quad;
    logic [4:0]         r_it;

    // output register
    logic               r_ovalid, r_ogw, r_osat;
    logic signed [47:0] r_opx, r_opy, r_oph;

    t_md_req            w_req;
    t_md_rsp            md_rsp;
    logic               w_small;
    logic signed [63:0] w_full, w_q, w_mod, w_cc, w_sn, w_cs, w_xs, w_ys, w_at;
    logic [31:0]        w_t, w_tq, w_u;
    logic [63:0]        w_px64, w_py64, w_ph64;
    t_sat               w_setx, w_sety, w_seth, w_hacc, w_padx, w_pady;

    twodo_muldiv u_md (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (md_rsp)
    );

    always_comb begin
        w_small = (r_dh < SMALL_H) && (r_dh > -SMALL_H);
        w_full  = r_two ? DEG_TWO_TURNS : DEG_TURN;
        w_q     = md_rsp.q;
        w_mod   = (r_ang[63] && md_rsp.rem != 64'd0) ? w_full - $signed(md_rsp.rem)
                                                      : $signed(md_rsp.rem);
        w_t     = w_q[31:0];
        w_tq    = w_t + 32'h2000_0000;
        w_u     = w_t - {w_tq[31:30], 30'd0};
        w_cc    = r_cx - w_q;
        unique case (r_quad)
            2'd0: begin w_sn = r_s;   w_cs = w_cc;  end
            2'd1: begin w_sn = w_cc;  w_cs = -r_s;  end
            2'd2: begin w_sn = -r_s;  w_cs = -w_cc; end
            default: begin w_sn = -w_cc; w_cs = r_s; end
        endcase
        w_xs   = r_cx >>> r_it;
        w_ys   = r_cy >>> r_it;
        w_at   = atan_turn(r_it);
        w_setx = sat_add(64'sd0, 64'(i_in.new_x));
        w_sety = sat_add(64'sd0, 64'(i_in.new_y));
        w_seth = sat_add(64'sd0, 64'(i_in.new_heading));
        w_hacc = sat_add(64'(r_ph), r_dh);
        w_padx = sat_add(64'(r_px), r_t - w_q);
        w_pady = sat_add(64'(r_py), r_t + w_q);
        w_px64 = 64'(r_px);
        w_py64 = 64'(r_py);
        w_ph64 = 64'(r_ph);
    end

    // operand selection for the shared unit
    always_comb begin
        w_req.start = (r_state == S_ISSUE);
        w_req.a     = '0;
        w_req.b     = '0;
        w_req.d     = '0;
        unique case (r_step)
            P_DL: begin w_req.a = 64'(r_del_l); w_req.b = 64'(r_lwt); w_req.d = TRAVEL_DIV; end
            P_DR: begin w_req.a = 64'(r_del_r); w_req.b = 64'(r_rwt); w_req.d = TRAVEL_DIV; end
            P_DS: begin w_req.a = 64'(r_del_s); w_req.b = 64'(r_swt); w_req.d = TRAVEL_DIV; end
            P_DH: begin
                if (r_use_gyro) begin
                    w_req.a = 64'(r_del_g);
                    w_req.b = 64'(r_gs);
                    w_req.d = CD_PER_DEG;
                end else begin
                    w_req.a = r_dl - r_dr;
                    w_req.b = RAD2DEG_Q16;
                    w_req.d = 64'(r_lo) + 64'(r_ro);
                end
            end
            T_MOD: begin w_req.a = r_ang; w_req.b = UNIT_ONE; w_req.d = w_full; end
            T_TURN: begin
                w_req.a = r_t;
                if (r_mode == M_GSET) begin
                    w_req.b = CD_PER_DEG;
                    w_req.d = DEG_Q16;
                end else begin
                    w_req.b = TURN_Q32;
                    w_req.d = w_full;
                end
            end
            T_ZR: begin w_req.a = r_cz; w_req.b = PI_Q30; w_req.d = HALF_TURN_Q31; end
            T_S:  begin w_req.a = r_cx; w_req.b = r_t; w_req.d = ONE_Q30; end
            T_C:  begin w_req.a = r_cy; w_req.b = r_t; w_req.d = ONE_Q30; end
            A_A: begin
                if (w_small) begin
                    w_req.a = r_dh; w_req.b = PI_Q30; w_req.d = DEG_HALF_TURN;
                end else begin
                    w_req.a = r_sh; w_req.b = DEG_TURN; w_req.d = UNIT_ONE;
                end
            end
            A_B: begin
                if (w_small) begin
                    w_req.a = r_t; w_req.b = r_t; w_req.d = ARC_DIV;
                end else begin
                    w_req.a = r_t; w_req.b = INV_PI_Q30; w_req.d = r_dh;
                end
            end
            A_C:   begin w_req.a = r_t; w_req.b = UNIT_ONE; w_req.d = ONE_Q30; end
            P_DY1: begin w_req.a = r_dl + r_dr; w_req.b = r_c; w_req.d = TWO_Q30; end
            P_DY2: begin
                w_req.a = 64'(r_ro) - 64'(r_lo); w_req.b = r_sh; w_req.d = ONE_Q30;
            end
            P_DX1: begin w_req.a = r_ds; w_req.b = r_c; w_req.d = ONE_Q30; end
            P_DX2: begin w_req.a = 64'(r_so); w_req.b = r_sh <<< 1; w_req.d = ONE_Q30; end
            P_X1:  begin w_req.a = r_dx; w_req.b = r_hc; w_req.d = ONE_Q30; end
            P_X2:  begin w_req.a = r_dy; w_req.b = r_hs; w_req.d = ONE_Q30; end
            P_Y1:  begin w_req.a = r_dx; w_req.b = r_hs; w_req.d = ONE_Q30; end
            P_Y2:  begin w_req.a = r_dy; w_req.b = r_hc; w_req.d = ONE_Q30; end
            default: begin w_req.a = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lwt      <= '0;
            r_rwt      <= '0;
            r_swt      <= '0;
            r_lo       <= '0;
            r_ro       <= '0;
            r_so       <= '0;
            r_gs       <= 18'd65536;
            r_use_gyro <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEFT_TRAVEL:   r_lwt      <= i_cfg_data[23:0];
                CFG_RIGHT_TRAVEL:  r_rwt      <= i_cfg_data[23:0];
                CFG_STRAFE_TRAVEL: r_swt      <= i_cfg_data[23:0];
                CFG_LEFT_OFFSET:   r_lo       <= i_cfg_data;
                CFG_RIGHT_OFFSET:  r_ro       <= i_cfg_data;
                CFG_STRAFE_OFFSET: r_so       <= i_cfg_data;
                CFG_GYRO_SCALE:    r_gs       <= i_cfg_data[17:0];
                CFG_USE_GYRO:      r_use_gyro <= i_cfg_data[0];
                default:           r_use_gyro <= r_use_gyro;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= P_DL;
            r_mode   <= M_ARC;
            r_last_l <= '0;
            r_last_r <= '0;
            r_last_s <= '0;
            r_last_g <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_ph     <= '0;
            r_ovalid <= 1'b0;
            r_it     <= '0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.req_type) begin
                            if (i_in.set_mask[0]) r_px <= w_setx.val;
                            if (i_in.set_mask[1]) r_py <= w_sety.val;
                            if (i_in.set_mask[2]) r_ph <= w_seth.val;
                            r_sat <= (i_in.set_mask[0] & w_setx.flag)
                                   | (i_in.set_mask[1] & w_sety.flag)
                                   | (i_in.set_mask[2] & w_seth.flag);
                            r_gw  <= i_in.set_mask[2] & r_use_gyro;
                            if (i_in.set_mask[2] && r_use_gyro) begin
                                r_ang   <= 64'(w_seth.val);
                                r_two   <= 1'b0;
                                r_mode  <= M_GSET;
                                r_step  <= T_MOD;
                                r_state <= S_ISSUE;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_sat    <= 1'b0;
                            r_gw     <= 1'b0;
                            r_del_l  <= 33'(i_in.left_angle) - 33'(r_last_l);
                            r_del_r  <= 33'(i_in.right_angle) - 33'(r_last_r);
                            r_del_s  <= 33'(i_in.strafe_angle) - 33'(r_last_s);
                            r_last_l <= i_in.left_angle;
                            r_last_r <= i_in.right_angle;
                            r_last_s <= i_in.strafe_angle;
                            r_del_g  <= $signed({1'b0, i_in.gyro_heading})
                                      - $signed({1'b0, r_last_g});
                            if (r_use_gyro) r_last_g <= i_in.gyro_heading;
                            r_step  <= P_DL;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (md_rsp.done) begin
                        unique case (r_step)
                            P_DL: begin
                                r_dl <= w_q; r_step <= P_DR; r_state <= S_ISSUE;
                            end
                            P_DR: begin
                                r_dr <= w_q; r_step <= P_DS; r_state <= S_ISSUE;
                            end
                            P_DS: begin
                                r_ds <= w_q; r_step <= P_DH; r_state <= S_ISSUE;
                            end
                            P_DH: begin
                                r_dh    <= w_q;
                                r_state <= S_ISSUE;
                                if (w_q == 64'sd0) begin
                                    r_c    <= ONE_Q30;
                                    r_sh   <= '0;
                                    r_step <= P_DY1;
                                end else begin
                                    r_ang  <= w_q;
                                    r_two  <= 1'b1;
                                    r_mode <= M_ARC;
                                    r_step <= T_MOD;
                                end
                            end
                            T_MOD: begin
                                r_t <= w_mod; r_step <= T_TURN; r_state <= S_ISSUE;
                            end
                            T_TURN: begin
                                if (r_mode == M_GSET) begin
                                    r_last_g <= (w_q >= GYRO_FULL) ? 16'd0 : w_q[15:0];
                                    r_state  <= S_OUT;
                                end else begin
                                    r_quad  <= w_tq[31:30];
                                    r_cz    <= 64'($signed(w_u));
                                    r_cx    <= GAIN_Q30;
                                    r_cy    <= '0;
                                    r_it    <= '0;
                                    r_state <= S_CORD;
                                end
                            end
                            T_ZR: begin
                                r_t <= w_q; r_step <= T_S; r_state <= S_ISSUE;
                            end
                            T_S: begin
                                r_s <= r_cy + w_q; r_step <= T_C; r_state <= S_ISSUE;
                            end
                            T_C: begin
                                r_state <= S_ISSUE;
                                if (r_mode == M_ARC) begin
                                    r_sh   <= w_sn;
                                    r_step <= A_A;
                                end else begin
                                    r_hs   <= w_sn;
                                    r_hc   <= w_cs;
                                    r_step <= P_X1;
                                end
                            end
                            A_A: begin
                                r_t <= w_q; r_step <= A_B; r_state <= S_ISSUE;
                            end
                            A_B: begin
                                r_state <= S_ISSUE;
                                if (w_small) begin
                                    r_c    <= ONE_Q30 - w_q;
                                    r_step <= P_DY1;
                                end else begin
                                    r_t    <= w_q;
                                    r_step <= A_C;
                                end
                            end
                            A_C: begin
                                r_c <= w_q; r_step <= P_DY1; r_state <= S_ISSUE;
                            end
                            P_DY1: begin
                                r_dy <= w_q; r_step <= P_DY2; r_state <= S_ISSUE;
                            end
                            P_DY2: begin
                                r_dy <= r_dy + w_q; r_step <= P_DX1; r_state <= S_ISSUE;
                            end
                            P_DX1: begin
                                r_dx <= w_q; r_step <= P_DX2; r_state <= S_ISSUE;
                            end
                            P_DX2: begin
                                r_dx    <= r_dx + w_q;
                                r_ph    <= w_hacc.val;
                                r_sat   <= r_sat | w_hacc.flag;
                                r_ang   <= 64'(w_hacc.val);
                                r_two   <= 1'b0;
                                r_mode  <= M_HEAD;
                                r_step  <= T_MOD;
                                r_state <= S_ISSUE;
                            end
                            P_X1: begin
                                r_t <= w_q; r_step <= P_X2; r_state <= S_ISSUE;
                            end
                            P_X2: begin
                                r_px    <= w_padx.val;
                                r_sat   <= r_sat | w_padx.flag;
                                r_step  <= P_Y1;
                                r_state <= S_ISSUE;
                            end
                            P_Y1: begin
                                r_t <= w_q; r_step <= P_Y2; r_state <= S_ISSUE;
                            end
                            P_Y2: begin
                                r_py    <= w_pady.val;
                                r_sat   <= r_sat | w_pady.flag;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CORD: begin
                    if (!r_cz[63]) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - w_at;
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + w_at;
                    end
                    if (r_it == IT_LAST) begin
                        r_step  <= T_ZR;
                        r_state <= S_ISSUE;
                    end else begin
                        r_it <= r_it + 5'd1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_opx   <= w_px64[47:0];
                        r_opy   <= w_py64[47:0];
                        r_oph   <= w_ph64[47:0];
                        r_ogw   <= r_gw;
                        r_osat  <= r_sat;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.pose_x       = r_opx;
    assign o_out.pose_y       = r_opy;
    assign o_out.pose_heading = r_oph;
    assign o_out.gyro_write   = r_ogw;
    assign o_out.saturated    = r_osat;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a word is in progress");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == S_WAIT))
        else $error("muldiv result with no sequencer waiting");

    a_issue_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> !md_rsp.busy)
        else $error("muldiv started while busy");

    a_cordic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORD) |-> (r_it <= IT_LAST))
        else $error("CORDIC step count overrun");

endmodule

### hdl/twodo_muldiv.sv
// Shared multiply-divide unit: round(a * b / d), ties away from zero, saturating.
module twodo_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  twodo_pkg::t_md_req i_req,
    output twodo_pkg::t_md_rsp o_rsp
);
    import twodo_pkg::*;

    typedef enum logic [4:0] {
        U_IDLE = 5'b00001,
        U_MUL  = 5'b00010,
        U_CHK  = 5'b00100,
        U_DIV  = 5'b01000,
        U_RND  = 5'b10000
    } t_ustate;

    t_ustate            r_state;
    logic [63:0]        r_ua, r_ub, r_ud;
    logic               r_neg;
    logic [127:0]       r_acc;
    logic [63:0]        r_pp;
    logic [1:0]         r_pps;
    logic [2:0]         r_k;
    logic [5:0]         r_cnt;
    logic signed [63:0] r_q;
    logic [63:0]        r_rem;
    logic               r_done;

    logic [31:0]  w_ah, w_bh;
    logic [63:0]  w_prod;
    logic [127:0] w_ppx;
    logic [64:0]  w_sh, w_sub;
    logic         w_ge;
    logic [63:0]  w_rem, w_qr, w_qs;

    always_comb begin
        w_ah   = r_k[1] ? r_ua[63:32] : r_ua[31:0];
        w_bh   = r_k[0] ? r_ub[63:32] : r_ub[31:0];
        w_prod = w_ah * w_bh;
        w_ppx  = {64'd0, r_pp} << {r_pps, 5'd0};
        w_sh   = r_acc[127:63];
        w_sub  = w_sh - {1'b0, r_ud};
        w_ge   = w_sh >= {1'b0, r_ud};
        w_rem  = r_acc[127:64];
        w_qr   = r_acc[63:0] + ((w_rem >= r_ud - w_rem) ? 64'd1 : 64'd0);
        w_qs   = (w_qr > MAX64) ? MAX64 : w_qr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == U_RND)
                    || ((r_state == U_CHK) && ((r_ud == 64'd0) || (r_acc[127:64] >= r_ud)));
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_ua    <= i_req.a[63] ? 64'd0 - i_req.a : i_req.a;
                        r_ub    <= i_req.b[63] ? 64'd0 - i_req.b : i_req.b;
                        r_ud    <= i_req.d[63] ? 64'd0 - i_req.d : i_req.d;
                        r_neg   <= i_req.a[63] ^ i_req.b[63] ^ i_req.d[63];
                        r_acc   <= '0;
                        r_k     <= 3'd0;
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    if (r_k != 3'd4) begin
                        r_pp  <= w_prod;
                        r_pps <= {1'b0, r_k[1]} + {1'b0, r_k[0]};
                    end
                    if (r_k != 3'd0) begin
                        r_acc <= r_acc + w_ppx;
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) begin
                        r_state <= U_CHK;
                    end
                end
                U_CHK: begin
                    r_rem <= r_acc[127:64];
                    r_cnt <= 6'd0;
                    if (r_ud == 64'd0) begin
                        r_q     <= '0;
                        r_state <= U_IDLE;
                    end else if (r_acc[127:64] >= r_ud) begin
                        r_q     <= r_neg ? -$signed(MAX64) : $signed(MAX64);
                        r_state <= U_IDLE;
                    end else begin
                        r_state <= U_DIV;
                    end
                end
                U_DIV: begin
                    r_acc <= {(w_ge ? w_sub[63:0] : w_sh[63:0]), r_acc[62:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= U_RND;
                    end
                end
                U_RND: begin
                    r_q     <= r_neg ? -$signed(w_qs) : $signed(w_qs);
                    r_rem   <= w_rem;
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_rsp.busy = (r_state != U_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

### verif/testbench.sv
// Self-checking testbench of the tracking wheel odometry core with its own pose predictor.
module testbench;
    import twodo_pkg::*;

    localparam int     TRIG_N   = 16;
    localparam longint POSE_MAX = 64'sd140737488355327;
    localparam longint SAT64    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int     WATCHDOG = 20000;
    localparam int     HOLD_LEN = 4000;

    typedef struct {
        bit             req_type;
        logic [31:0]    left_angle;
        logic [31:0]    right_angle;
        logic [31:0]    strafe_angle;
        logic [15:0]    gyro_heading;
        logic [47:0]    new_x;
        logic [47:0]    new_y;
        logic [47:0]    new_heading;
        logic [2:0]     set_mask;
    } t_word;

    typedef struct {
        logic [47:0] pose_x;
        logic [47:0] pose_y;
        logic [47:0] pose_heading;
        bit          gyro_write;
        bit          saturated;
    } t_pose;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [24:0] cfg_data;

    twodo_in_if  in_ch ();
    twodo_out_if out_ch ();

    tracking_wheel_odometry_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    t_word  pending_words[$];
    t_pose  expected_poses[$];
    int     errors;
    int     idle_pct;
    int     quiet_cycles;
    int     poses_seen;
    int     hold_cnt;

    // model copy of registers and state
    longint m_travel[3];
    longint m_lo, m_ro, m_so, m_gscale;
    bit     m_use_gyro;
    longint m_last_l, m_last_r, m_last_s, m_last_g;
    longint m_x, m_y, m_h;

    // generator angle tracking
    longint g_l, g_r, g_s, g_g;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint mul_div(longint a, longint b, longint d);
        longint unsigned ua, ub, ud, q;
        logic [127:0]    p, qq, rr;
        bit              neg;
        ua  = (a < 0) ? 64'd0 - 64'(a) : 64'(a);
        ub  = (b < 0) ? 64'd0 - 64'(b) : 64'(b);
        ud  = (d < 0) ? 64'd0 - 64'(d) : 64'(d);
        neg = ((a < 0) != (b < 0)) != (d < 0);
        if (ud == 0) return 0;
        p = {64'd0, ua} * {64'd0, ub};
        if (p[127:64] >= ud) begin
            q = SAT64;
        end else begin
            qq = p / {64'd0, ud};
            rr = p % {64'd0, ud};
            q  = qq[63:0];
            if (rr[63:0] >= ud - rr[63:0]) q++;
            if (q > SAT64) q = SAT64;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sext(longint unsigned v, int w);
        longint unsigned m;
        m = 64'd1 << (w - 1);
        v &= (64'd1 << w) - 1;
        return longint'(v ^ m) - longint'(m);
    endfunction

    function automatic longint clamp_add(longint a, longint b, inout bit flag);
        if (b > 0 && a > POSE_MAX - b) begin
            flag = 1'b1;
            return POSE_MAX;
        end
        if (b < 0 && a < -POSE_MAX - 1 - b) begin
            flag = 1'b1;
            return -POSE_MAX - 1;
        end
        return a + b;
    endfunction

    function automatic longint unsigned turn_of(longint a, longint full);
        longint r;
        r = a % full;
        if (r < 0) r += full;
        return 64'(mul_div(r, TURN_Q32, full)) & 64'hFFFF_FFFF;
    endfunction

    task automatic cordic(input longint unsigned t, output longint sn, output longint cs);
        longint unsigned q, u;
        longint          z, x, y, zr, s, c, xs, ys;
        q = ((t + 64'h2000_0000) >> 30) & 64'd3;
        u = (t - (q << 30)) & 64'hFFFF_FFFF;
        z = u[31] ? longint'(u) - TURN_Q32 : longint'(u);
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < TRIG_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_turn(5'(i));
            end else begin
                x += ys; y -= xs; z += atan_turn(5'(i));
            end
        end
        zr = mul_div(z, PI_Q30, HALF_TURN_Q31);
        s  = y + mul_div(x, zr, ONE_Q30);
        c  = x - mul_div(y, zr, ONE_Q30);
        case (q)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endtask

    task automatic predict_pose(input t_word w, output t_pose p);
        bit     sat, gw;
        longint la, ra, sa, g, dl, dr, ds, dh, c, sh, ch, hs, hc, dx, dy, hr, r, cd;
        sat = 0;
        gw  = 0;
        if (w.req_type) begin
            if (w.set_mask[0]) m_x = clamp_add(0, sext(w.new_x, 48), sat);
            if (w.set_mask[1]) m_y = clamp_add(0, sext(w.new_y, 48), sat);
            if (w.set_mask[2]) begin
                m_h = clamp_add(0, sext(w.new_heading, 48), sat);
                if (m_use_gyro) begin
                    r = m_h % DEG_TURN;
                    if (r < 0) r += DEG_TURN;
                    cd = mul_div(r, CD_PER_DEG, DEG_Q16);
                    m_last_g = (cd >= GYRO_FULL) ? 0 : cd;
                    gw = 1;
                end
            end
        end else begin
            la = sext(w.left_angle, 32);
            ra = sext(w.right_angle, 32);
            sa = sext(w.strafe_angle, 32);
            g  = w.gyro_heading;
            dl = mul_div(la - m_last_l, m_travel[0], TRAVEL_DIV);
            dr = mul_div(ra - m_last_r, m_travel[1], TRAVEL_DIV);
            ds = mul_div(sa - m_last_s, m_travel[2], TRAVEL_DIV);
            m_last_l = la;
            m_last_r = ra;
            m_last_s = sa;
            if (m_use_gyro) begin
                dh = mul_div(g - m_last_g, m_gscale, CD_PER_DEG);
                m_last_g = g;
            end else begin
                dh = mul_div(dl - dr, RAD2DEG_Q16, m_lo + m_ro);
            end
            if (dh == 0) begin
                c  = ONE_Q30;
                sh = 0;
            end else begin
                cordic(turn_of(dh, DEG_TWO_TURNS), sh, ch);
                if (dh < SMALL_H && dh > -SMALL_H) begin
                    hr = mul_div(dh, PI_Q30, DEG_HALF_TURN);
                    c  = ONE_Q30 - mul_div(hr, hr, 24 * ONE_Q30);
                end else begin
                    c = mul_div(mul_div(sh * DEG_TURN, INV_PI_Q30, dh), 1, ONE_Q30);
                end
            end
            dy  = mul_div(dl + dr, c, TWO_Q30) + mul_div(m_ro - m_lo, sh, ONE_Q30);
            dx  = mul_div(ds, c, ONE_Q30) + mul_div(m_so, 2 * sh, ONE_Q30);
            m_h = clamp_add(m_h, dh, sat);
            cordic(turn_of(m_h, DEG_TURN), hs, hc);
            m_x = clamp_add(m_x, mul_div(dx, hc, ONE_Q30) - mul_div(dy, hs, ONE_Q30), sat);
            m_y = clamp_add(m_y, mul_div(dx, hs, ONE_Q30) + mul_div(dy, hc, ONE_Q30), sat);
        end
        p.pose_x       = m_x[47:0];
        p.pose_y       = m_y[47:0];
        p.pose_heading = m_h[47:0];
        p.gyro_write   = gw;
        p.saturated    = sat;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input longint unsigned v);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v[24:0];
        case (idx)
            CFG_LEFT_TRAVEL:   m_travel[0] = v & 64'hFF_FFFF;
            CFG_RIGHT_TRAVEL:  m_travel[1] = v & 64'hFF_FFFF;
            CFG_STRAFE_TRAVEL: m_travel[2] = v & 64'hFF_FFFF;
            CFG_LEFT_OFFSET:   m_lo = sext(v, 25);
            CFG_RIGHT_OFFSET:  m_ro = sext(v, 25);
            CFG_STRAFE_OFFSET: m_so = sext(v, 25);
            CFG_GYRO_SCALE:    m_gscale = v & 64'h3_FFFF;
            CFG_USE_GYRO:      m_use_gyro = v[0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input longint unsigned lt, rt, st, lo, ro, so, gs, ug);
        write_reg(CFG_LEFT_TRAVEL, lt);
        write_reg(CFG_RIGHT_TRAVEL, rt);
        write_reg(CFG_STRAFE_TRAVEL, st);
        write_reg(CFG_LEFT_OFFSET, lo);
        write_reg(CFG_RIGHT_OFFSET, ro);
        write_reg(CFG_STRAFE_OFFSET, so);
        write_reg(CFG_GYRO_SCALE, gs);
        write_reg(CFG_USE_GYRO, ug);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_poses.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        return {$urandom, $urandom};
    endfunction

    task automatic push_sensor(input longint l, r, s, g);
        t_word w;
        w = '{default: '0};
        w.new_x        = rand48();
        w.new_y        = rand48();
        w.new_heading  = rand48();
        w.set_mask     = 3'($urandom);
        w.left_angle   = l[31:0];
        w.right_angle  = r[31:0];
        w.strafe_angle = s[31:0];
        w.gyro_heading = g[15:0];
        g_l = sext(l, 32);
        g_r = sext(r, 32);
        g_s = sext(s, 32);
        pending_words.push_back(w);
    endtask

    task automatic push_set(input logic [47:0] x, y, h, input logic [2:0] mask);
        t_word w;
        w.req_type     = 1'b1;
        w.left_angle   = $urandom;
        w.right_angle  = $urandom;
        w.strafe_angle = $urandom;
        w.gyro_heading = 16'($urandom_range(35999));
        w.new_x        = x;
        w.new_y        = y;
        w.new_heading  = h;
        w.set_mask     = mask;
        pending_words.push_back(w);
    endtask

    task automatic push_random();
        int     sel;
        longint span, dl, dr;
        sel = $urandom_range(99);
        if (sel < 10) begin
            push_set(rand48() >>> $urandom_range(47), rand48() >>> $urandom_range(47),
                     rand48() >>> $urandom_range(47), 3'($urandom));
        end else if (sel < 15) begin
            push_sensor($urandom, $urandom, $urandom, $urandom_range(35999));
        end else begin
            span = longint'(1) << $urandom_range(16);
            dl   = longint'($urandom_range(2 * span)) - span;
            dr   = (sel < 30) ? dl : longint'($urandom_range(2 * span)) - span;
            if ($urandom_range(3) == 0) g_g = $urandom_range(35999);
            else g_g = (g_g + $urandom_range(400) + 35800) % 36000;
            push_sensor(g_l + dl, g_r + dr, g_s + longint'($urandom_range(2 * span)) - span,
                        g_g);
        end
    endtask

    task automatic random_geometry(input bit extreme);
        if (extreme) begin
            set_geometry($urandom_range(1) ? 24'hFF_FFFF : 0, $urandom_range(1) ? 24'hFF_FFFF : 0,
                         $urandom_range(1) ? 24'hFF_FFFF : 0,
                         $urandom_range(1) ? 25'h0FF_FFFF : 25'h100_0000,
                         $urandom_range(1) ? 25'h0FF_FFFF : 25'h100_0000,
                         $urandom_range(1) ? 25'h0FF_FFFF : 25'h100_0000,
                         $urandom_range(1) ? 18'h3_FFFF : 0, $urandom_range(1));
        end else begin
            set_geometry($urandom_range(16777215), $urandom_range(16777215),
                         $urandom_range(16777215),
                         $urandom_range(1000000, 4000000), 64'd0 - $urandom_range(4000000),
                         64'(longint'($urandom_range(8000000)) - 4000000),
                         $urandom_range(262143), $urandom_range(1));
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                in_ch.valid        <= 1'b1;
                in_ch.req_type     <= pending_words[0].req_type;
                in_ch.left_angle   <= pending_words[0].left_angle;
                in_ch.right_angle  <= pending_words[0].right_angle;
                in_ch.strafe_angle <= pending_words[0].strafe_angle;
                in_ch.gyro_heading <= pending_words[0].gyro_heading;
                in_ch.new_x        <= pending_words[0].new_x;
                in_ch.new_y        <= pending_words[0].new_y;
                in_ch.new_heading  <= pending_words[0].new_heading;
                in_ch.set_mask     <= pending_words[0].set_mask;
                void'(pending_words.pop_front());
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // prediction on input acceptance
    always @(posedge i_clk) begin
        t_word w;
        t_pose p;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            w.req_type     = in_ch.req_type;
            w.left_angle   = in_ch.left_angle;
            w.right_angle  = in_ch.right_angle;
            w.strafe_angle = in_ch.strafe_angle;
            w.gyro_heading = in_ch.gyro_heading;
            w.new_x        = in_ch.new_x;
            w.new_y        = in_ch.new_y;
            w.new_heading  = in_ch.new_heading;
            w.set_mask     = in_ch.set_mask;
            predict_pose(w, p);
            expected_poses.push_back(p);
        end
    end

    // output receiver, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            out_ch.ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (out_ch.valid && out_ch.ready && poses_seen == 150) begin
            out_ch.ready <= 1'b0;
            hold_cnt <= HOLD_LEN;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            poses_seen <= poses_seen + 1;
            if (expected_poses.size() == 0) begin
                $display("%0t: unexpected word x=%h y=%h h=%h", $time, out_ch.pose_x,
                         out_ch.pose_y, out_ch.pose_heading);
                errors++;
            end else begin
                e = expected_poses.pop_front();
                if (out_ch.pose_x !== e.pose_x || out_ch.pose_y !== e.pose_y ||
                    out_ch.pose_heading !== e.pose_heading ||
                    out_ch.gyro_write !== e.gyro_write || out_ch.saturated !== e.saturated) begin
                    $display("%0t: mismatch exp x=%h y=%h h=%h gw=%b sat=%b", $time,
                             e.pose_x, e.pose_y, e.pose_heading, e.gyro_write, e.saturated);
                    $display("%0t:          got x=%h y=%h h=%h gw=%b sat=%b", $time,
                             out_ch.pose_x, out_ch.pose_y, out_ch.pose_heading,
                             out_ch.gyro_write, out_ch.saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        errors = 0; idle_pct = 34; quiet_cycles = 0; poses_seen = 0; hold_cnt = 0;
        m_travel = '{0, 0, 0}; m_lo = 0; m_ro = 0; m_so = 0; m_gscale = 65536;
        m_use_gyro = 0; m_last_l = 0; m_last_r = 0; m_last_s = 0; m_last_g = 0;
        m_x = 0; m_y = 0; m_h = 0; g_l = 0; g_r = 0; g_s = 0; g_g = 0;
        cfg_we = 0; cfg_idx = CFG_LEFT_TRAVEL; cfg_data = '0;
        in_ch.valid = 0; in_ch.req_type = 0; in_ch.left_angle = 0; in_ch.right_angle = 0;
        in_ch.strafe_angle = 0; in_ch.gyro_heading = 0; in_ch.new_x = 0; in_ch.new_y = 0;
        in_ch.new_heading = 0; in_ch.set_mask = 0; out_ch.ready = 0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: extreme fields, set-pose masks
        push_sensor(0, 0, 0, 0);
        push_sensor(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 35999);
        push_set(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, 3'd7);
        push_set(48'h1234_5678_9ABC, 48'h0, 48'h0, 3'd0);
        push_set(0, 0, 0, 3'd7);
        wait_idle();

        // wheel mode with zero offset sum, then straight, then strafe into saturation
        set_geometry(24'h10_0000, 24'h10_0000, 24'hFF_FFFF, 25'd2000000,
                     25'h1E1_7B80, 25'd500000, 65536, 0);
        push_sensor(5000, -3000, 100, 0);
        wait_idle();
        write_reg(CFG_RIGHT_OFFSET, 25'd2000000);
        wait_idle();
        push_sensor(g_l + 7000, g_r + 7000, g_s, 0);
        push_sensor(g_l + 10, g_r - 10, g_s, 0);
        push_sensor(g_l + 90000, g_r - 90000, g_s, 0);
        push_set(48'h7FFF_FFFF_0000, 0, 0, 3'd1);
        push_sensor(g_l, g_r, g_s + 2000000000, 0);
        push_sensor(g_l, g_r, g_s - 2000000000, 0);
        wait_idle();

        // IMU mode: heading set with wrap, small and large heading changes
        write_reg(CFG_USE_GYRO, 1);
        write_reg(CFG_GYRO_SCALE, 18'h3_FFFF);
        push_set(0, 0, 48'hFFFF_FFF0_0000, 3'd4);
        push_set(0, 0, 48'h0000_0168_0000, 3'd4);
        push_sensor(g_l, g_r, g_s, 0);
        push_sensor(g_l + 100, g_r + 100, g_s, 1);
        push_sensor(g_l, g_r, g_s, 35999);
        push_sensor(g_l, g_r, g_s, 17999);
        wait_idle();

        g_g = 17999;
        for (int ph = 0; ph < 7; ph++) begin
            idle_pct = (ph == 2) ? 0 : 34;
            random_geometry(ph == 1 || ph == 4);
            for (int n = 0; n < 100; n++) push_random();
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
hdl/twodo_pkg.sv
hdl/twodo_in_if.sv
hdl/twodo_out_if.sv
hdl/twodo_muldiv.sv
hdl/tracking_wheel_odometry_core.sv
verif/testbench.sv
